// File: rtl/periodic_timer_catch_up_backoff_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic timer with catch-up and backoff
// Concurrent checks that are compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_CATCH_UP_BACKOFF_MACROS_SVH
`define PERIODIC_TIMER_CATCH_UP_BACKOFF_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an antecedent implies a consequent in the same cycle
`define PTCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define PTCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTCB_ASSERT_SAME(label, ante, cons, msg)
`define PTCB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/ptcb_pkg.sv
// ----------------------------------------------------------------------------
// ptcb_pkg
// Types and constants of the periodic timer with catch-up and backoff.
// ----------------------------------------------------------------------------
package ptcb_pkg;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int PERIOD_W   = 32;
    localparam int INTERVAL_W = 35;
    localparam int OUT_IVL_W  = 34;
    localparam int INDEX_W    = 4;
    localparam int CFG_IDX_W  = 4;

    // Fires allowed from one tick before the reference snaps to the stamp
    localparam int MAX_CATCH_UP = 10;

    // Reset value of the period and of the working interval
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    // Operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_SHOT = CFG_IDX_W'(1);

    // Input request
    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
    } in_t;

    // Result item
    typedef struct packed {
        logic [INDEX_W-1:0]   fire_index;
        logic                 last_of_run;
        logic [OUT_IVL_W-1:0] working_interval;
        logic                 running;
    } out_t;

endpackage

// File: rtl/periodic_timer_catch_up_backoff.sv
// ----------------------------------------------------------------------------
// periodic_timer_catch_up_backoff
// Periodic or one-shot timer fed by time stamps, with catch-up and backoff.
// ----------------------------------------------------------------------------
// Start, stop and restart requests are done in the idle state. A tick on a
// running timer goes through a setup step and a check step, then one fire step
// per fire (up to ten), plus a final step to write back the reference time
// when a periodic run ends short of the catch-up limit; a tick that causes no
// fire returns from its accept, setup or check step. Every step goes through
// one shared 48-bit subtract unit and one comparator under a small sequencer,
// so the block takes no new request until the current one is done. Fires stall
// while the result register is full and not taken. Configuration writes are
// always taken. There is no clearing pass after reset.

`include "periodic_timer_catch_up_backoff_macros.svh"

module periodic_timer_catch_up_backoff (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input requests
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  ptcb_pkg::in_t                         s_data,
    // Fire results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ptcb_pkg::out_t                        m_data,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptcb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ptcb_pkg::PERIOD_W-1:0]         cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_FIRE  = 5'b01000,
        ST_FINAL = 5'b10000
    } state_t;

    localparam int TW = ptcb_pkg::TIME_W;
    localparam int IW = ptcb_pkg::INTERVAL_W;
    localparam int PW = ptcb_pkg::PERIOD_W;
    localparam int XW = ptcb_pkg::INDEX_W;
    localparam logic [XW-1:0] LAST_INDEX = XW'(ptcb_pkg::MAX_CATCH_UP - 1);

    // Configuration and timer state
    logic [PW-1:0]  period_reg, period_next;
    logic           single_shot_reg, single_shot_next;
    logic [TW-1:0]  ref_reg, ref_next;
    logic [IW-1:0]  ivl_reg, ivl_next;
    logic           running_reg, running_next;

    // Sequencer and working registers
    state_t         state_reg, state_next;
    logic [TW-1:0]  now_reg, now_next;
    logic [TW-1:0]  rem_reg, rem_next;
    logic [XW-1:0]  count_reg, count_next;
    logic           backoff_reg, backoff_next;

    // Result register
    logic           m_valid_reg, m_valid_next;
    ptcb_pkg::out_t m_data_reg, m_data_next;

    // Shared subtract unit and comparator
    logic [TW-1:0]  sub_a, sub_b;
    logic [TW:0]    sub_diff;
    logic [TW-1:0]  cmp_a, cmp_b;
    logic           cmp_ge;

    logic           s_fire;
    logic           out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Pick operands of the shared unit by step
    always_comb begin
        sub_a = rem_reg;
        sub_b = TW'(ivl_reg);
        cmp_a = rem_reg;
        cmp_b = TW'(ivl_reg);
        unique case (state_reg)
            ST_SETUP: begin
                sub_a = now_reg;
                sub_b = ref_reg;
            end
            ST_CHECK: begin
                cmp_b = TW'(ivl_reg);
            end
            ST_FIRE: begin
                // rem - ivl >= ivl is the same as rem >= 2 * ivl
                cmp_b = TW'({ivl_reg, 1'b0});
            end
            ST_FINAL: begin
                sub_a = now_reg;
                sub_b = rem_reg;
            end
            default: begin
                sub_a = rem_reg;
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign cmp_ge   = (cmp_a >= cmp_b);

    // Sequence requests, fires and configuration writes
    always_comb begin
        period_next      = period_reg;
        single_shot_next = single_shot_reg;
        ref_next         = ref_reg;
        ivl_next         = ivl_reg;
        running_next     = running_reg;
        state_next       = state_reg;
        now_next         = now_reg;
        rem_next         = rem_reg;
        count_next       = count_reg;
        backoff_next     = backoff_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Write configuration; a zero period is ignored
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == ptcb_pkg::CFG_PERIOD) begin
                if (cfg_data != '0) begin
                    period_next = cfg_data;
                end
            end else if (cfg_index == ptcb_pkg::CFG_SINGLE_SHOT) begin
                single_shot_next = cfg_data[0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    now_next = s_data.now;
                    unique case (s_data.op)
                        ptcb_pkg::OP_TICK: begin
                            if (running_reg) begin
                                state_next = ST_SETUP;
                            end
                        end
                        ptcb_pkg::OP_START: begin
                            if (!running_reg) begin
                                ivl_next     = IW'(period_reg);
                                ref_next     = s_data.now;
                                running_next = 1'b1;
                            end
                        end
                        ptcb_pkg::OP_STOP: begin
                            running_next = 1'b0;
                        end
                        ptcb_pkg::OP_RESTART: begin
                            ivl_next     = IW'(period_reg);
                            ref_next     = s_data.now;
                            running_next = 1'b1;
                        end
                        default: begin
                            running_next = running_reg;
                        end
                    endcase
                end
            end

            ST_SETUP: begin
                // Form elapsed time; a stamp before the reference ends the tick
                rem_next     = sub_diff[TW-1:0];
                count_next   = '0;
                backoff_next = (ivl_reg < {1'b0, period_reg, 2'b00});
                state_next   = sub_diff[TW] ? ST_IDLE : ST_CHECK;
            end

            ST_CHECK: begin
                state_next = cmp_ge ? ST_FIRE : ST_IDLE;
            end

            ST_FIRE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.fire_index  = count_reg;
                    if (single_shot_reg) begin
                        // One-shot: stop and keep the reference
                        running_next                 = 1'b0;
                        m_data_next.last_of_run      = 1'b1;
                        m_data_next.working_interval = ivl_reg[ptcb_pkg::OUT_IVL_W-1:0];
                        m_data_next.running          = 1'b0;
                        state_next                   = ST_IDLE;
                    end else if (count_reg == LAST_INDEX) begin
                        // Catch-up limit: snap to the stamp, back off the interval
                        ref_next = now_reg;
                        if (backoff_reg) begin
                            ivl_next = {ivl_reg[IW-2:0], 1'b0};
                        end
                        m_data_next.last_of_run      = 1'b1;
                        m_data_next.working_interval =
                            ivl_next[ptcb_pkg::OUT_IVL_W-1:0];
                        m_data_next.running          = running_reg;
                        state_next                   = ST_IDLE;
                    end else begin
                        // Advance by one interval
                        rem_next                     = sub_diff[TW-1:0];
                        count_next                   = count_reg + XW'(1);
                        m_data_next.last_of_run      = !cmp_ge;
                        m_data_next.working_interval = ivl_reg[ptcb_pkg::OUT_IVL_W-1:0];
                        m_data_next.running          = running_reg;
                        state_next                   = cmp_ge ? ST_FIRE : ST_FINAL;
                    end
                end
            end

            ST_FINAL: begin
                // Reference moves to the stamp less what is left over
                ref_next   = sub_diff[TW-1:0];
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= ptcb_pkg::PERIOD_RESET;
            single_shot_reg <= 1'b0;
            ref_reg         <= '0;
            ivl_reg         <= IW'(ptcb_pkg::PERIOD_RESET);
            running_reg     <= 1'b0;
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
        end else begin
            period_reg      <= period_next;
            single_shot_reg <= single_shot_next;
            ref_reg         <= ref_next;
            ivl_reg         <= ivl_next;
            running_reg     <= running_next;
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Hold working values and the result payload
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        rem_reg     <= rem_next;
        count_reg   <= count_next;
        backoff_reg <= backoff_next;
        m_data_reg  <= m_data_next;
    end

    // Checks
    `PTCB_ASSERT_SAME(a_result_from_fire, !m_valid_reg && m_valid_next, state_reg == ST_FIRE, "result raised outside a fire step")
    `PTCB_ASSERT_SAME(a_fire_has_interval, state_reg == ST_FIRE, rem_reg >= TW'(ivl_reg), "fire step without a whole interval left")
    `PTCB_ASSERT_SAME(a_index_in_range, m_valid_reg, m_data_reg.fire_index <= LAST_INDEX, "fire index beyond catch-up limit")
    `PTCB_ASSERT_NEXT(a_single_shot_stops, state_reg == ST_FIRE && out_free && single_shot_reg, !running_reg && state_reg == ST_IDLE, "one-shot fire left timer running")

endmodule

// File: tb/sv/ptcb_checker.sv
// ----------------------------------------------------------------------------
// ptcb_checker
// Watches the request, fire and configuration channels of the periodic timer,
// keeps its own copy of the timer state, predicts the fires of each accepted
// tick and compares every accepted fire field by field with the oldest
// prediction. Hands the failure count and the number of open fires to the top.
// ----------------------------------------------------------------------------
module ptcb_checker
    import ptcb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_t                  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_t                 m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data,
    output int                   fail_count,
    output int                   fires_pending
);

    // Shadow copy of the timer registers and state
    logic [PERIOD_W-1:0]   period_q   = PERIOD_RESET;
    logic                  one_shot_q = 1'b0;
    logic [TIME_W-1:0]     ref_time   = '0;
    logic [INTERVAL_W-1:0] interval   = INTERVAL_W'(PERIOD_RESET);
    logic                  armed      = 1'b0;
    out_t                  fires_q[$];

    // Count a failure; print only the first few
    function automatic void flag_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ptcb_checker: %s mismatch: expected 'h%0h, got 'h%0h",
                     field, want, got);
        end
    endfunction

    // Arm the timer unless it already runs
    function automatic void arm_timer(input logic [TIME_W-1:0] stamp);
        if (!armed) begin
            interval = INTERVAL_W'(period_q);
            ref_time = stamp;
            armed    = 1'b1;
        end
    endfunction

    // Queue the fires that one tick causes and advance the shadow state
    function automatic void predict_fires(input logic [TIME_W-1:0] stamp);
        out_t fire;
        int   n;
        logic done;
        n    = 0;
        done = 1'b0;
        if (!armed || stamp < ref_time) begin
            return;
        end
        while (!done && (stamp - ref_time) >= TIME_W'(interval)) begin
            if (one_shot_q) begin
                // One-shot: stop, keep the reference
                armed = 1'b0;
                done  = 1'b1;
            end else begin
                ref_time = ref_time + TIME_W'(interval);
                if (n + 1 == MAX_CATCH_UP) begin
                    // Catch-up limit: snap to the stamp and back off
                    ref_time = stamp;
                    if (interval < (INTERVAL_W'(period_q) << 2)) begin
                        interval = interval << 1;
                    end
                    done = 1'b1;
                end
            end
            if (!done && (stamp - ref_time) < TIME_W'(interval)) begin
                done = 1'b1;
            end
            fire.fire_index       = INDEX_W'(n);
            fire.last_of_run      = done;
            fire.working_interval = interval[OUT_IVL_W-1:0];
            fire.running          = armed;
            fires_q.push_back(fire);
            n++;
        end
    endfunction

    // Compare fires, track register writes, predict from requests
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            period_q   = PERIOD_RESET;
            one_shot_q = 1'b0;
            ref_time   = '0;
            interval   = INTERVAL_W'(PERIOD_RESET);
            armed      = 1'b0;
            fires_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (fires_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ptcb_checker: fire with none expected: 'h%0h", m_data);
                    end
                end else begin
                    want = fires_q.pop_front();
                    if (m_data.fire_index !== want.fire_index)
                        flag_field("fire_index", want.fire_index, m_data.fire_index);
                    if (m_data.last_of_run !== want.last_of_run)
                        flag_field("last_of_run", want.last_of_run, m_data.last_of_run);
                    if (m_data.working_interval !== want.working_interval)
                        flag_field("working_interval", want.working_interval,
                                   m_data.working_interval);
                    if (m_data.running !== want.running)
                        flag_field("running", want.running, m_data.running);
                end
            end
            if (cfg_valid && cfg_ready) begin
                // Drop a zero period; other indexes are ignored
                if (cfg_index == CFG_PERIOD && cfg_data != '0) begin
                    period_q = cfg_data;
                end else if (cfg_index == CFG_SINGLE_SHOT) begin
                    one_shot_q = cfg_data[0];
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.op)
                    OP_TICK: begin
                        predict_fires(s_data.now);
                    end
                    OP_START: begin
                        arm_timer(s_data.now);
                    end
                    OP_STOP: begin
                        armed = 1'b0;
                    end
                    OP_RESTART: begin
                        armed = 1'b0;
                        arm_timer(s_data.now);
                    end
                    default: begin
                    end
                endcase
            end
        end
        fires_pending = fires_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the periodic timer with a directed set of requests and then with
// phases of random tick sequences under several period and one-shot settings,
// with random gaps on the request side and random stalls on the fire side.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_top;
    import ptcb_pkg::*;

    localparam logic [TIME_W-1:0]   MAX_STAMP     = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = '1;
    localparam int                  PHASES        = 8;
    localparam int                  PHASE_ITEMS   = 54;
    localparam int                  SETTLE_CYCLES = 20;
    localparam int                  DRAIN_LIMIT   = 5000;
    localparam int unsigned         CYCLE_LIMIT   = 2000000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PERIOD_W-1:0]  cfg_data  = '0;

    int                   fail_count;
    int                   fires_pending;
    int unsigned          cycle_count = 0;

    // Stimulus view of the timer: stamp clock and settings in force
    longint unsigned      t_cur      = 0;
    logic [PERIOD_W-1:0]  cur_period = PERIOD_RESET;
    logic                 one_shot   = 1'b0;
    logic                 calm       = 1'b0;

    periodic_timer_catch_up_backoff u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptcb_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .fires_pending (fires_pending)
    );

    // Clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Stall the fire side: mostly short stalls, a few long, long stall-free runs
    initial begin
        int run_len;
        int stall_len;
        @(posedge aclk);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 4);
            m_ready <= 1'b0;
            repeat (stall_len) @(posedge aclk);
        end
    end

    // Idle cycles before the next request
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the stamp clock by a random number of periods plus a remainder
    function automatic logic [TIME_W-1:0] advance_clock();
        longint unsigned k;
        longint unsigned frac;
        longint unsigned step;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 25)      k = 0;
        else if (r < 65) k = 1;
        else if (r < 85) k = $urandom_range(2, 4);
        else if (r < 95) k = $urandom_range(5, 12);
        else             k = $urandom_range(13, 40);
        r = $urandom_range(0, 9);
        if (r < 2)      frac = 0;
        else if (r < 3) frac = cur_period - 1;
        else            frac = $urandom_range(0, cur_period - 1);
        step = k * cur_period + frac;
        if (t_cur + step > MAX_STAMP) begin
            // Hit the top of the stamp range: tick there once, then wrap low
            t_cur = {16'($urandom_range(0, 16'h00FF)), 32'($urandom)};
            return MAX_STAMP;
        end
        t_cur = t_cur + step;
        return TIME_W'(t_cur);
    endfunction

    // Present one request and hold it until accepted
    task automatic put_req(input op_t op, input logic [TIME_W-1:0] stamp);
        in_t req;
        int  gap;
        req.op  = op;
        req.now = stamp;
        gap     = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Write one register; only called while the timer is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PERIOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PERIOD && value != '0) begin
            cur_period = value;
        end else if (idx == CFG_SINGLE_SHOT) begin
            one_shot = value[0];
        end
        @(posedge aclk);
    endtask

    // Drop the request, wait for all open fires, let the write-back finish
    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (fires_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random request of a well-formed tick sequence, with some noise
    task automatic random_req();
        int              r;
        int              restart_share;
        longint unsigned back;
        restart_share = one_shot ? 30 : 8;
        r = $urandom_range(0, 99);
        if (r < restart_share) begin
            put_req(OP_RESTART, TIME_W'(t_cur));
        end else if (r < restart_share + 5) begin
            put_req(OP_START, TIME_W'(t_cur));
        end else if (r < restart_share + 11) begin
            put_req(OP_STOP, {16'($urandom), 32'($urandom)});
        end else if (r < restart_share + 16) begin
            // Tick with a stamp behind the clock
            back = $urandom_range(1, cur_period);
            put_req(OP_TICK, TIME_W'((t_cur > back) ? t_cur - back : 0));
        end else if (r < restart_share + 19) begin
            put_req(OP_TICK, {16'($urandom), 32'($urandom)});
        end else begin
            put_req(OP_TICK, advance_clock());
        end
    endtask

    initial begin
        int ph;
        int n;
        logic [PERIOD_W-1:0] p;

        // Hold reset, then release it
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset period, control corner cases, catch-up and backoff
        put_req(OP_TICK,    48'd5000);
        put_req(OP_STOP,    48'd5000);
        put_req(OP_START,   48'd0);
        put_req(OP_START,   48'd500);
        put_req(OP_TICK,    48'd999);
        put_req(OP_TICK,    48'd1000);
        put_req(OP_TICK,    48'd3500);
        put_req(OP_TICK,    48'd2000);
        put_req(OP_TICK,    48'd100000);
        put_req(OP_TICK,    48'd200000);
        put_req(OP_TICK,    48'd300000);
        put_req(OP_RESTART, 48'd300500);
        put_req(OP_STOP,    48'd301000);
        put_req(OP_TICK,    48'd400000);
        settle();

        // Directed: largest period, zero write ignored, full stamp range
        write_reg(CFG_PERIOD, '0);
        write_reg(CFG_PERIOD, '1);
        write_reg(CFG_SINGLE_SHOT, 32'hFFFF_FFFE);
        write_reg(CFG_UNUSED, 32'h5A5A_A5A5);
        put_req(OP_RESTART, 48'd0);
        put_req(OP_TICK,    48'h8000_0000_0000);
        put_req(OP_TICK,    MAX_STAMP);
        put_req(OP_TICK,    MAX_STAMP);
        settle();

        // Directed: smallest period in one-shot mode
        write_reg(CFG_PERIOD, 32'd1);
        write_reg(CFG_SINGLE_SHOT, 32'd1);
        put_req(OP_RESTART, 48'd10);
        put_req(OP_TICK,    48'd10);
        put_req(OP_TICK,    48'd11);
        put_req(OP_TICK,    48'd20);
        put_req(OP_START,   48'd20);
        put_req(OP_TICK,    48'd100);
        settle();

        // Random phases under different settings
        t_cur = {16'($urandom_range(0, 16'hFF00)), 32'($urandom)};
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       p = 32'd1;
                1:       p = $urandom_range(2, 16);
                2:       p = '1;
                3:       p = $urandom_range(100, 5000);
                4:       p = $urandom;
                5:       p = $urandom_range(2, 64);
                6:       p = $urandom_range(1, 1000);
                default: p = 32'h8000_0000 | $urandom;
            endcase
            if (ph == 4) begin
                write_reg(CFG_PERIOD, '0);
            end
            if (ph == 5) begin
                write_reg(CFG_UNUSED, $urandom);
            end
            write_reg(CFG_PERIOD, p);
            write_reg(CFG_SINGLE_SHOT,
                      {31'($urandom), (ph == 3 || ph == 6) ? 1'b1 : 1'b0});
            calm = ($urandom_range(0, 3) == 0);
            // Keep the old working interval in some phases
            if (ph == 0 || $urandom_range(0, 1) == 0) begin
                t_cur = {16'($urandom_range(0, 16'hFF00)), 32'($urandom)};
                put_req(OP_RESTART, TIME_W'(t_cur));
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                random_req();
            end
            settle();
        end

        if (fires_pending != 0) begin
            $display("tb_top: %0d expected fires never arrived", fires_pending);
        end
        if (fail_count == 0 && fires_pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ptcb_pkg.sv
rtl/periodic_timer_catch_up_backoff.sv
tb/sv/ptcb_checker.sv
tb/sv/tb_top.sv
